### design/rss_pkg.sv
// Shared constants, types and helpers for the running sample statistics core.
// No dependencies; used by rss_div and running_sample_statistics_core.
package rss_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int DELTA_BITS   = 33;
  localparam int DIV_CNT_BITS = $clog2(DELTA_BITS + 1);
  localparam int PROD_BITS    = 2 * DELTA_BITS;
  localparam int CNT_EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [COUNT_BITS-1:0] TALLY_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic signed [47:0]    SUM_MAX     = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0]    SUM_MIN     = {1'b1, {47{1'b0}}};
  localparam logic [62:0]           M2_MAX      = {63{1'b1}};
  localparam logic signed [31:0]    S32_MAX     = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0]    S32_MIN     = {1'b1, {31{1'b0}}};

  typedef struct packed {
    logic                  start;
    logic [DELTA_BITS-1:0] dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DELTA_BITS-1:0] quotient;
  } div_rsp_t;

  function automatic logic [15:0] count_to_out(input logic [COUNT_BITS-1:0] t);
    logic [CNT_EXT_BITS-1:0] wide;
    wide = '0;
    wide[COUNT_BITS-1:0] = t;
    return wide[15:0];
  endfunction

endpackage

### design/running_sample_statistics_core.sv
// Running sample statistics core: count, sum, min, max, Welford mean and m2.
// Depends on rss_pkg and the bit-serial divider rss_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one signed Q16.16
//   sample per request. Output channel (out_valid / out_stall / out_*) gives
//   one result request per sample with every statistic after that sample.
//   in_stall is high while a sample is being worked on; a request is taken
//   only when the sequencer is idle.
// Sequence:
//   An accepted sample runs through the serial divider (one quotient bit per
//   cycle for the 33-bit deviation divided by the new count, after which the
//   divider hands the quotient back), then a step that updates the mean and the
//   second deviation, a step for the 33x33 product and one to accumulate m2.
//   A sample taken while the count is full skips the arithmetic and goes
//   straight to the last step, which gives its result flagged dropped.
//   in_stall drops in the cycle out_valid rises, so no new sample is taken
//   until the result of the last one is in the output register.
// Stall:
//   The result sits in an output register; a new sample may be accepted while
//   it waits. If a second result is ready before the first is taken, the
//   sequencer holds in its last step until out_stall drops.
// Reset:
//   Synchronous, active low. Count, sum, mean and m2 clear to zero, the minimum
//   goes to the most positive value and the maximum to the most negative.
module running_sample_statistics_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sample_count,
  output logic [47:0] out_running_sum,
  output logic [31:0] out_smallest,
  output logic [31:0] out_largest,
  output logic [31:0] out_running_mean,
  output logic [62:0] out_squared_deviation_sum,
  output logic        out_dropped
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r;

  // statistics state
  logic [rss_pkg::COUNT_BITS-1:0] tally_r;
  logic signed [47:0]             total_r;
  logic signed [31:0]             low_r;
  logic signed [31:0]             high_r;
  logic signed [31:0]             avg_r;
  logic [62:0]                    acc_r;

  // per-sample working registers
  logic signed [31:0]             x_r;
  logic [rss_pkg::DELTA_BITS-1:0] dmag_r;
  logic                           dneg_r;
  logic [rss_pkg::DELTA_BITS-1:0] d2mag_r;
  logic [rss_pkg::PROD_BITS-1:0]  prod_r;
  logic                           drop_r;

  // output register
  logic        out_valid_r;
  logic [15:0] o_count_r;
  logic [47:0] o_sum_r;
  logic [31:0] o_small_r;
  logic [31:0] o_large_r;
  logic [31:0] o_mean_r;
  logic [62:0] o_m2_r;
  logic        o_drop_r;

  rss_pkg::div_req_t div_req;
  rss_pkg::div_rsp_t div_rsp;

  logic                           accept;
  logic                           full;
  logic signed [48:0]             sum_wide;
  logic signed [47:0]             total_nxt;
  logic signed [32:0]             delta;
  logic [rss_pkg::DELTA_BITS-1:0] dmag_nxt;
  logic signed [33:0]             step;
  logic signed [33:0]             avg_wide;
  logic signed [31:0]             avg_nxt;
  logic signed [33:0]             delta2;
  logic [33:0]                    d2abs;
  logic [66:0]                    m2_wide;
  logic [62:0]                    acc_nxt;
  logic                           out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (tally_r == rss_pkg::TALLY_LIMIT);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    // saturating running sum
    sum_wide = {total_r[47], total_r} + {{17{in_sample[31]}}, in_sample};
    if (sum_wide[48] != sum_wide[47]) begin
      total_nxt = sum_wide[48] ? rss_pkg::SUM_MIN : rss_pkg::SUM_MAX;
    end else begin
      total_nxt = sum_wide[47:0];
    end

    // first deviation, split into sign and magnitude for the divider
    delta    = {in_sample[31], in_sample} - {avg_r[31], avg_r};
    dmag_nxt = delta[32] ? 33'(-delta) : 33'(delta);

    // mean update from the truncated quotient, then the second deviation
    step     = dneg_r ? -$signed({1'b0, div_rsp.quotient})
                      : $signed({1'b0, div_rsp.quotient});
    avg_wide = {{2{avg_r[31]}}, avg_r} + step;
    avg_nxt  = avg_wide[31:0];
    delta2   = {{2{x_r[31]}}, x_r} - {{2{avg_nxt[31]}}, avg_nxt};
    d2abs    = delta2[33] ? 34'(-delta2) : 34'(delta2);

    // saturating m2 accumulate
    m2_wide  = {4'b0, acc_r} + {1'b0, prod_r};
    acc_nxt  = (m2_wide > {4'b0, rss_pkg::M2_MAX}) ? rss_pkg::M2_MAX : m2_wide[62:0];
  end

  assign div_req.start    = accept && !full;
  assign div_req.dividend = dmag_nxt;
  assign div_req.divisor  = tally_r + rss_pkg::COUNT_BITS'(1);

  rss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer and statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tally_r <= '0;
      total_r <= '0;
      low_r   <= rss_pkg::S32_MAX;
      high_r  <= rss_pkg::S32_MIN;
      avg_r   <= '0;
      acc_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_r    <= in_sample;
            drop_r <= full;
            if (full) begin
              // counter full: skip all arithmetic, report unchanged state
              state_r <= ST_FIN;
            end else begin
              tally_r <= tally_r + rss_pkg::COUNT_BITS'(1);
              total_r <= total_nxt;
              if ($signed(in_sample) < low_r) low_r <= in_sample;
              if ($signed(in_sample) > high_r) high_r <= in_sample;
              dmag_r  <= dmag_nxt;
              dneg_r  <= delta[32];
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) state_r <= ST_AVG;
        end
        ST_AVG: begin
          avg_r   <= avg_nxt;
          d2mag_r <= d2abs[32:0];
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          // deviations share a sign, so magnitudes multiply to m2's increment
          prod_r  <= rss_pkg::PROD_BITS'(dmag_r) * rss_pkg::PROD_BITS'(d2mag_r);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold here until the output register can take the result
          if (out_free) begin
            if (!drop_r) acc_r <= acc_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        o_count_r   <= rss_pkg::count_to_out(tally_r);
        o_sum_r     <= total_r;
        o_small_r   <= low_r;
        o_large_r   <= high_r;
        o_mean_r    <= avg_r;
        o_m2_r      <= drop_r ? acc_r : acc_nxt;
        o_drop_r    <= drop_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_sample_count          = o_count_r;
  assign out_running_sum           = o_sum_r;
  assign out_smallest              = o_small_r;
  assign out_largest               = o_large_r;
  assign out_running_mean          = o_mean_r;
  assign out_squared_deviation_sum = o_m2_r;
  assign out_dropped               = o_drop_r;

  // a non-full request must launch the divider
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && tally_r != rss_pkg::TALLY_LIMIT |=>
      state_r == ST_DIV && div_rsp.busy)
    else $error("accepted sample did not start the divider");

  // the divider is idle whenever the sequencer can take a request
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // a dropped result reports a full counter
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |->
      out_sample_count == rss_pkg::count_to_out(rss_pkg::TALLY_LIMIT))
    else $error("dropped result without full counter");

  // after any accepted sample, minimum never exceeds maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dropped |-> $signed(out_smallest) <= $signed(out_largest))
    else $error("minimum above maximum");

endmodule

### design/rss_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on rss_pkg for widths and the request/response structs.
module rss_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rss_pkg::div_req_t req,
  output rss_pkg::div_rsp_t rsp
);

  logic [rss_pkg::DELTA_BITS-1:0]   quo_r;
  logic [rss_pkg::COUNT_BITS-1:0]   rem_r;
  logic [rss_pkg::COUNT_BITS-1:0]   divisor_r;
  logic [rss_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;

  logic [rss_pkg::COUNT_BITS:0]     trial;
  logic                             ge;
  logic [rss_pkg::COUNT_BITS:0]     diff;
  logic [rss_pkg::COUNT_BITS-1:0]   rem_nxt;
  logic [rss_pkg::DELTA_BITS-1:0]   quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[rss_pkg::DELTA_BITS-1]};
    ge      = trial >= {1'b0, divisor_r};
    diff    = trial - {1'b0, divisor_r};
    // remainder stays below the divisor, so the top bit drops out
    rem_nxt = ge ? diff[rss_pkg::COUNT_BITS-1:0] : trial[rss_pkg::COUNT_BITS-1:0];
    quo_nxt = {quo_r[rss_pkg::DELTA_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= rss_pkg::DIV_CNT_BITS'(rss_pkg::DELTA_BITS);
        quo_r     <= req.dividend;
        rem_r     <= '0;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - rss_pkg::DIV_CNT_BITS'(1);
        if (cnt_r == rss_pkg::DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### sim/running_sample_statistics_core_tb.sv
// Self-checking bench for running_sample_statistics_core: feeds Q16.16 samples and checks
// every statistic of each result against a built-in Welford tracker.
// Depends on rss_pkg and the core RTL only.
module running_sample_statistics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold-off length used to back the core up into in_stall.
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [31:0] sample;
    bit          drain_first;  // hold the request until every result is back
  } sample_req_t;

  typedef struct {
    logic [15:0] count;
    logic [47:0] total;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mean;
    logic [62:0] m2;
    logic        dropped;
  } stats_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_sample_count;
  logic [47:0] out_running_sum;
  logic [31:0] out_smallest;
  logic [31:0] out_largest;
  logic [31:0] out_running_mean;
  logic [62:0] out_squared_deviation_sum;
  logic        out_dropped;

  // Tracker state, mirrors the core's statistics after every accepted request.
  logic [rss_pkg::COUNT_BITS-1:0] acc_count = '0;
  logic signed [47:0]             acc_sum   = '0;
  logic signed [31:0]             acc_min   = rss_pkg::S32_MAX;
  logic signed [31:0]             acc_max   = rss_pkg::S32_MIN;
  logic signed [31:0]             acc_mean  = '0;
  logic [62:0]                    acc_m2    = '0;

  sample_req_t sample_backlog[$];
  stats_t      stats_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_trigger = 1'b0;
  logic        req_accepted = 1'b0;
  int unsigned fault_count = 0;
  int unsigned results_seen = 0;
  int          walk_level = 0;

  running_sample_statistics_core u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_sample                 (in_sample),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_sample_count          (out_sample_count),
    .out_running_sum           (out_running_sum),
    .out_smallest              (out_smallest),
    .out_largest               (out_largest),
    .out_running_mean          (out_running_mean),
    .out_squared_deviation_sum (out_squared_deviation_sum),
    .out_dropped               (out_dropped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fold one sample into the tracker and return the statistics the core must report.
  // Once the counter is full the sample is dropped and nothing moves.
  function automatic stats_t fold_sample(input logic signed [31:0] x);
    stats_t            r;
    longint            xl;
    longint            sum_l;
    longint            mean_l;
    longint            n_l;
    longint            delta;
    longint            delta2;
    longint            quot;
    longint unsigned   mag1;
    longint unsigned   mag2;
    longint unsigned   prod;
    longint unsigned   room;
    logic [31:0]       count_wide;
    r.dropped = (acc_count == rss_pkg::TALLY_LIMIT);
    if (!r.dropped) begin
      acc_count = acc_count + rss_pkg::COUNT_BITS'(1);
      xl = longint'(x);
      // Saturate the sum at the 48-bit signed limits.
      sum_l = longint'(acc_sum);
      sum_l = sum_l + xl;
      if (sum_l > rss_pkg::SUM_MAX) begin
        sum_l = rss_pkg::SUM_MAX;
      end
      if (sum_l < rss_pkg::SUM_MIN) begin
        sum_l = rss_pkg::SUM_MIN;
      end
      acc_sum = 48'(sum_l);
      if (x < acc_min) begin
        acc_min = x;
      end
      if (x > acc_max) begin
        acc_max = x;
      end
      // Welford step; signed division truncates toward zero.
      mean_l = longint'(acc_mean);
      n_l = longint'(acc_count);
      delta = xl - mean_l;
      quot = delta / n_l;
      acc_mean = 32'(mean_l + quot);
      mean_l = longint'(acc_mean);
      delta2 = xl - mean_l;
      // Both deviations share a sign, so multiply magnitudes.
      mag1 = (delta < 0) ? -delta : delta;
      mag2 = (delta2 < 0) ? -delta2 : delta2;
      prod = mag1 * mag2;
      room = 64'(rss_pkg::M2_MAX - acc_m2);
      if (prod > room) begin
        acc_m2 = rss_pkg::M2_MAX;
      end else begin
        acc_m2 = 63'(64'(acc_m2) + prod);
      end
    end
    count_wide = 32'(acc_count);
    r.count = count_wide[15:0];
    r.total = acc_sum;
    r.lo    = acc_min;
    r.hi    = acc_max;
    r.mean  = acc_mean;
    r.m2    = acc_m2;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 what, results_seen, want, got);
      end
    end
  endtask

  // Samples of modest size keep m2 well clear of saturation for the whole run,
  // so it stays a live check until the wide tail at the end of the run.
  function automatic logic [31:0] pick_moderate();
    int v;
    case ($urandom_range(0, 9))
      0: v = (int'($urandom_range(0, 30)) - 15) * 65536;
      1, 2, 3: v = int'($urandom_range(0, 2097151)) - 1048576;
      4, 5: v = walk_level + int'($urandom_range(0, 510)) - 255;
      6: v = walk_level;
      7: begin
        v = int'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      8: v = int'($urandom_range(0, 6)) - 3;
      default: v = (int'($urandom_range(0, 2097151)) - 1048576) & ~32'hFFFF;
    endcase
    walk_level = v;
    return v;
  endfunction

  task automatic queue_moderate(input int n);
    sample_req_t req;
    for (int i = 0; i < n; i++) begin
      req.sample = pick_moderate();
      req.drain_first = ($urandom_range(0, 39) == 0);
      sample_backlog.insert(sample_backlog.size(), req);
    end
  endtask

  // Full-range samples, led by both extremes; these saturate m2.
  task automatic queue_wide(input int n);
    sample_req_t req;
    for (int i = 0; i < n; i++) begin
      case (i)
        0: req.sample = rss_pkg::S32_MAX;
        1: req.sample = rss_pkg::S32_MIN;
        default: begin
          case ($urandom_range(0, 5))
            0: req.sample = rss_pkg::S32_MAX;
            1: req.sample = rss_pkg::S32_MIN;
            2: req.sample = ($urandom_range(0, 1) == 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: req.sample = $urandom;
          endcase
        end
      endcase
      req.drain_first = ($urandom_range(0, 9) == 0);
      sample_backlog.insert(sample_backlog.size(), req);
    end
  endtask

  // Wait until every request went in and every result came back.
  task automatic settle();
    while (sample_backlog.size() != 0 || in_valid || stats_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Start one long receiver hold-off, once something is in flight.
  task automatic hold_receiver();
    while (stats_due.size() == 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    hold_trigger = 1'b1;
    @(negedge clk);
    hold_trigger = 1'b0;
  endtask

  // Driver: advance to the next request once the current one was taken,
  // otherwise hold valid and payload steady.
  always @(negedge clk) begin : sample_driver
    sample_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted) begin
      if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!sample_backlog[0].drain_first || stats_due.size() == 0)) begin
        nxt = sample_backlog.pop_front();
        in_valid  <= 1'b1;
        in_sample <= nxt.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, forced high during a hold-off.
  always @(negedge clk) begin : result_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Hold-off counter, counted in its own process.
  always @(posedge clk) begin : hold_counter
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_trigger) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: check each taken result against the oldest expectation, then
  // fold any sample taken on this edge into the tracker.
  always @(posedge clk) begin : monitor
    stats_t want;
    req_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("result %0d arrived with nothing expected", results_seen);
        end
      end else begin
        want = stats_due.pop_front();
        check_field("sample_count", 64'(out_sample_count), 64'(want.count));
        check_field("running_sum", 64'(out_running_sum), 64'(want.total));
        check_field("smallest", 64'(out_smallest), 64'(want.lo));
        check_field("largest", 64'(out_largest), 64'(want.hi));
        check_field("running_mean", 64'(out_running_mean), 64'(want.mean));
        check_field("squared_deviation_sum", 64'(out_squared_deviation_sum),
                    64'(want.m2));
        check_field("dropped", 64'(out_dropped), 64'(want.dropped));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      stats_due.insert(stats_due.size(), fold_sample(in_sample));
    end
  end

  initial begin : stimulus
    sample_req_t req;
    logic [31:0] directed[$];

    send_idle_pct = 38;
    recv_idle_pct = 52;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: most negative sample first (it sets both extremes and
    // a large but bounded m2), then zero, unit steps, fractions and repeats.
    directed = '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
                 32'h000F_FFFF, 32'hFFF0_0001, 32'h0005_0000, 32'h0005_0000,
                 32'h0005_0000, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0010_0000};
    foreach (directed[i]) begin
      req.sample = directed[i];
      req.drain_first = (i == 10);
      sample_backlog.insert(sample_backlog.size(), req);
    end

    queue_moderate(180);
    hold_receiver();
    settle();

    send_idle_pct = 52;
    recv_idle_pct = 38;
    queue_moderate(180);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_moderate(180);
    settle();

    // Finish with a full-range stretch that drives m2 into saturation.
    queue_wide(40);
    settle();

    repeat (100) @(posedge clk);
    if (fault_count == 0 && stats_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
design/rss_pkg.sv
design/rss_div.sv
design/running_sample_statistics_core.sv
sim/running_sample_statistics_core_tb.sv
